FILE: design/mlb_pkg.sv
`timescale 1ns / 1ps

package mlb_pkg;

   localparam int unsigned SeqDepthDefault = 11;
   localparam int unsigned UnitW           = 8;
   localparam int unsigned CharW           = 8;
   localparam int unsigned CsrIndexW       = 3;
   localparam int unsigned SymCountW       = 3;
   localparam int unsigned MaxSymbols      = 5;

   // register reset values, in 10 ms units
   localparam logic [UnitW-1:0] DotReset    = 8'd20;
   localparam logic [UnitW-1:0] DashReset   = 8'd60;
   localparam logic [UnitW-1:0] GapReset    = 8'd20;
   localparam logic [UnitW-1:0] LetterReset = 8'd100;
   localparam logic [UnitW-1:0] IdleReset   = 8'd10;
   localparam logic [UnitW-1:0] UnitsMax    = 8'hFF;

   // register indexes
   localparam logic [CsrIndexW-1:0] RegDot    = 3'd0;
   localparam logic [CsrIndexW-1:0] RegDash   = 3'd1;
   localparam logic [CsrIndexW-1:0] RegGap    = 3'd2;
   localparam logic [CsrIndexW-1:0] RegLetter = 3'd3;
   localparam logic [CsrIndexW-1:0] RegIdle   = 3'd4;

   // item commands
   localparam logic CmdSetChar = 1'b0;
   localparam logic CmdTick    = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FILL,
      ST_FINISH
   } ctrl_state_type;

   // one character of the table; bit i of dash_mask set means symbol i is a dash
   typedef struct packed {
      logic                 found;
      logic [SymCountW-1:0] sym_count;
      logic [MaxSymbols-1:0] dash_mask;
   } morse_entry_type;

   typedef struct packed {
      logic tick;     // advance playback by one unit
      logic reply;    // load the result register
      logic nf;       // not_found value for the reply
      logic latch;    // capture the looked-up character
      logic fill;     // write one symbol pair into the store
      logic finish;   // commit the new character and restart playback
   } mlb_cmd_type;

   typedef struct packed {
      logic same_char;
      logic found;
      logic last_sym;
      logic rsp_free;
   } mlb_status_type;

   function automatic morse_entry_type morse_lookup(input logic [CharW-1:0] ch);
      morse_entry_type e;
      e = '{found: 1'b1, sym_count: 3'd0, dash_mask: 5'b00000};
      unique case (ch)
         8'h43:   e = '{found: 1'b1, sym_count: 3'd4, dash_mask: 5'b00101}; // C -.-.
         8'h44:   e = '{found: 1'b1, sym_count: 3'd3, dash_mask: 5'b00001}; // D -..
         8'h45:   e = '{found: 1'b1, sym_count: 3'd1, dash_mask: 5'b00000}; // E .
         8'h49:   e = '{found: 1'b1, sym_count: 3'd2, dash_mask: 5'b00000}; // I ..
         8'h54:   e = '{found: 1'b1, sym_count: 3'd1, dash_mask: 5'b00001}; // T -
         8'h30:   e = '{found: 1'b1, sym_count: 3'd5, dash_mask: 5'b11111}; // 0 -----
         8'h31:   e = '{found: 1'b1, sym_count: 3'd5, dash_mask: 5'b11110}; // 1 .----
         8'h32:   e = '{found: 1'b1, sym_count: 3'd5, dash_mask: 5'b11100}; // 2 ..---
         8'h33:   e = '{found: 1'b1, sym_count: 3'd5, dash_mask: 5'b11000}; // 3 ...--
         8'h34:   e = '{found: 1'b1, sym_count: 3'd5, dash_mask: 5'b10000}; // 4 ....-
         8'h35:   e = '{found: 1'b1, sym_count: 3'd5, dash_mask: 5'b00000}; // 5 .....
         8'h36:   e = '{found: 1'b1, sym_count: 3'd5, dash_mask: 5'b00001}; // 6 -....
         8'h37:   e = '{found: 1'b1, sym_count: 3'd5, dash_mask: 5'b00011}; // 7 --...
         8'h38:   e = '{found: 1'b1, sym_count: 3'd5, dash_mask: 5'b00111}; // 8 ---..
         8'h39:   e = '{found: 1'b1, sym_count: 3'd5, dash_mask: 5'b01111}; // 9 ----.
         default: e = '{found: 1'b0, sym_count: 3'd0, dash_mask: 5'b00000};
      endcase
      return e;
   endfunction

endpackage

FILE: design/mlb_req_if.sv
`timescale 1ns / 1ps

interface mlb_req_if;
   logic                       valid;
   logic                       ready;
   logic                       cmd;
   logic [mlb_pkg::CharW-1:0]  char_code;

   modport source (output valid, output cmd, output char_code, input ready);
   modport sink   (input valid, input cmd, input char_code, output ready);
endinterface

FILE: design/mlb_rsp_if.sv
`timescale 1ns / 1ps

interface mlb_rsp_if;
   logic valid;
   logic ready;
   logic led_on;
   logic not_found;

   modport source (output valid, output led_on, output not_found, input ready);
   modport sink   (input valid, input led_on, input not_found, output ready);
endinterface

FILE: design/mlb_ctrl.sv
`timescale 1ns / 1ps

module mlb_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_cmd,
   output logic                    req_ready,
   input  mlb_pkg::mlb_status_type status,
   output mlb_pkg::mlb_cmd_type    cmd
);

   mlb_pkg::ctrl_state_type state_ff, state_in;
   logic                    accept;

   assign req_ready = (state_ff == mlb_pkg::ST_IDLE) && status.rsp_free;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mlb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mlb_pkg::ST_IDLE: begin
            if (accept && (req_cmd == mlb_pkg::CmdSetChar) && !status.same_char
                && status.found) begin
               state_in = mlb_pkg::ST_FILL;
            end
         end
         mlb_pkg::ST_FILL: begin
            if (status.last_sym) begin
               state_in = mlb_pkg::ST_FINISH;
            end
         end
         mlb_pkg::ST_FINISH: begin
            state_in = mlb_pkg::ST_IDLE;
         end
         default: begin
            state_in = mlb_pkg::ST_IDLE;
         end
      endcase
   end

   // commands
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         mlb_pkg::ST_IDLE: begin
            if (accept) begin
               priority if (req_cmd == mlb_pkg::CmdTick) begin
                  cmd.tick  = 1'b1;
                  cmd.reply = 1'b1;
               end else if (status.same_char) begin
                  cmd.reply = 1'b1;
               end else if (!status.found) begin
                  cmd.reply = 1'b1;
                  cmd.nf    = 1'b1;
               end else begin
                  cmd.latch = 1'b1;
               end
            end
         end
         mlb_pkg::ST_FILL: begin
            cmd.fill = 1'b1;
         end
         mlb_pkg::ST_FINISH: begin
            cmd.finish = 1'b1;
            cmd.reply  = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

`ifndef SYNTHESIS
   // a fill run ends only through the commit step
   a_fill_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mlb_pkg::ST_FILL) |=>
         (state_ff == mlb_pkg::ST_FILL || state_ff == mlb_pkg::ST_FINISH))
      else $error("fill left without commit");
   // the commit reply must never overwrite a pending result
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mlb_pkg::ST_FINISH) |-> status.rsp_free)
      else $error("result register busy at commit");
   // a new character is only latched on an accepted set item
   a_latch_src: assert property (@(posedge clock) disable iff (reset)
      cmd.latch |-> (req_valid && req_cmd == mlb_pkg::CmdSetChar && status.found))
      else $error("latch without set item");
`endif

endmodule

FILE: design/mlb_dp.sv
`timescale 1ns / 1ps

module mlb_dp #(
   parameter int unsigned SEQ_DEPTH = mlb_pkg::SeqDepthDefault
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [mlb_pkg::CsrIndexW-1:0]    csr_index,
   input  logic [mlb_pkg::UnitW-1:0]        csr_wdata,
   input  logic [mlb_pkg::CharW-1:0]        req_char_code,
   input  mlb_pkg::mlb_cmd_type             cmd,
   output mlb_pkg::mlb_status_type          status,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_led_on,
   output logic                             rsp_not_found
);

   localparam int unsigned IdxW  = $clog2(SEQ_DEPTH + 1);
   localparam int unsigned AddrW = $clog2(SEQ_DEPTH);

   // configuration
   logic [mlb_pkg::UnitW-1:0] dot_ff, dash_ff, gap_ff, letter_ff;

   // playback state
   logic [mlb_pkg::UnitW-1:0] store_ff [SEQ_DEPTH];
   logic [IdxW-1:0]           seq_len_ff, seq_len_in;
   logic [IdxW-1:0]           idx_ff, idx_in;
   logic [mlb_pkg::UnitW-1:0] elapsed_ff, elapsed_in;
   logic [mlb_pkg::CharW-1:0] shown_ff, shown_in;
   logic                      led_ff, led_in;

   // character being loaded
   logic [mlb_pkg::CharW-1:0]      char_ff;
   logic [mlb_pkg::SymCountW-1:0]  count_ff;
   logic [mlb_pkg::MaxSymbols-1:0] mask_ff;
   logic [mlb_pkg::SymCountW-1:0]  sym_ff;

   // result register
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_led_ff, rsp_nf_ff;

   mlb_pkg::morse_entry_type  entry;
   logic [mlb_pkg::UnitW-1:0] el_inc, dur_cur, first_dur, sym_dur, tail_dur;
   logic [AddrW-1:0]          rd_addr, wr_addr;
   logic                      last_sym;

   assign entry    = mlb_pkg::morse_lookup(req_char_code);
   assign last_sym = (sym_ff == count_ff - mlb_pkg::SymCountW'(1));

   assign status.same_char = (req_char_code == shown_ff);
   assign status.found     = entry.found;
   assign status.last_sym  = last_sym;
   assign status.rsp_free  = !rsp_valid_ff || rsp_ready;

   // configuration writes; indexes beyond the list are dropped. The idle pulse
   // length only takes effect through reset, which always applies its default.
   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff    <= mlb_pkg::DotReset;
         dash_ff   <= mlb_pkg::DashReset;
         gap_ff    <= mlb_pkg::GapReset;
         letter_ff <= mlb_pkg::LetterReset;
      end else if (csr_we) begin
         unique case (csr_index)
            mlb_pkg::RegDot:    dot_ff    <= csr_wdata;
            mlb_pkg::RegDash:   dash_ff   <= csr_wdata;
            mlb_pkg::RegGap:    gap_ff    <= csr_wdata;
            mlb_pkg::RegLetter: letter_ff <= csr_wdata;
            mlb_pkg::RegIdle:   ;
            default: ;
         endcase
      end
   end

   // one symbol pair per fill step: on time, then gap or letter gap
   assign wr_addr  = AddrW'({sym_ff, 1'b0});
   assign sym_dur  = mask_ff[sym_ff] ? dash_ff : dot_ff;
   assign tail_dur = last_sym ? letter_ff : gap_ff;

   // the store reloads the default idle pulse length on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < int'(SEQ_DEPTH); i++) begin
            store_ff[i] <= mlb_pkg::IdleReset;
         end
      end else if (cmd.fill) begin
         store_ff[wr_addr]                  <= sym_dur;
         store_ff[wr_addr + AddrW'(1)]      <= tail_dur;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         char_ff  <= req_char_code;
         count_ff <= entry.sym_count;
         mask_ff  <= entry.dash_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sym_ff <= '0;
      end else if (cmd.latch) begin
         sym_ff <= '0;
      end else if (cmd.fill) begin
         sym_ff <= sym_ff + mlb_pkg::SymCountW'(1);
      end
   end

   assign rd_addr   = idx_ff[AddrW-1:0];
   assign dur_cur   = (idx_ff < IdxW'(SEQ_DEPTH)) ? store_ff[rd_addr] : '0;
   assign el_inc    = (elapsed_ff == mlb_pkg::UnitsMax) ? mlb_pkg::UnitsMax
                                                        : elapsed_ff + 8'd1;
   assign first_dur = mask_ff[0] ? dash_ff : dot_ff;

   always_comb begin
      seq_len_in = seq_len_ff;
      idx_in     = idx_ff;
      elapsed_in = elapsed_ff;
      shown_in   = shown_ff;
      led_in     = led_ff;
      if (cmd.tick) begin
         if (idx_ff < seq_len_ff) begin
            if (el_inc >= dur_cur) begin
               idx_in     = idx_ff + IdxW'(1);
               elapsed_in = '0;
               led_in     = idx_ff[0];
            end else begin
               elapsed_in = el_inc;
            end
         end else begin
            idx_in     = '0;
            elapsed_in = el_inc;
         end
      end else if (cmd.finish) begin
         seq_len_in = IdxW'({count_ff, 1'b0});
         shown_in   = char_ff;
         elapsed_in = '0;
         if (first_dur == '0) begin
            idx_in = IdxW'(1);
            led_in = 1'b0;
         end else begin
            idx_in = '0;
            led_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_len_ff <= IdxW'(SEQ_DEPTH);
         idx_ff     <= '0;
         elapsed_ff <= '0;
         shown_ff   <= '0;
         led_ff     <= 1'b0;
      end else begin
         seq_len_ff <= seq_len_in;
         idx_ff     <= idx_in;
         elapsed_ff <= elapsed_in;
         shown_ff   <= shown_in;
         led_ff     <= led_in;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.reply) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.reply) begin
         rsp_led_ff <= led_in;
         rsp_nf_ff  <= cmd.nf;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_led_on    = rsp_led_ff;
   assign rsp_not_found = rsp_nf_ff;

`ifndef SYNTHESIS
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= seq_len_ff)
      else $error("play index beyond sequence length");
   a_restart_led: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> (led_ff == (idx_ff == '0)))
      else $error("LED level wrong after restart");
   a_len_shape: assert property (@(posedge clock) disable iff (reset)
      (seq_len_ff[0] == 1'b0) || (seq_len_ff == IdxW'(SEQ_DEPTH)))
      else $error("sequence length neither idle nor symbol pairs");
`endif

endmodule

FILE: design/morse_led_blinker.sv
`timescale 1ns / 1ps
// Tick item: result registered in the cycle after the transfer; one tick per cycle
//   while results are taken.
// Set-character item, new known character: latch, then one store symbol pair
//   written per cycle for n = 1..5 symbols, then the reply; other items wait.
// Reset is synchronous, active high: registers take their defaults, the duration
//   store reloads the idle pulse length at once, and playback shows the idle blink.

module morse_led_blinker #(
   parameter int unsigned SEQ_DEPTH = mlb_pkg::SeqDepthDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   mlb_req_if.sink                       req_ch,
   mlb_rsp_if.source                     rsp_ch,
   input  logic                          csr_we,
   input  logic [mlb_pkg::CsrIndexW-1:0] csr_index,
   input  logic [mlb_pkg::UnitW-1:0]     csr_wdata
);

   mlb_pkg::mlb_cmd_type    cmd;
   mlb_pkg::mlb_status_type status;

   // Controller: decides per transfer whether to tick, reply at once (same or
   // unknown character) or run the fill sequence over the duration store.
   mlb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_cmd   (req_ch.cmd),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: configuration registers, duration store, playback counters and
   // the result register that decouples the response side.
   mlb_dp #(
      .SEQ_DEPTH (SEQ_DEPTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_char_code (req_ch.char_code),
      .cmd           (cmd),
      .status        (status),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_led_on    (rsp_ch.led_on),
      .rsp_not_found (rsp_ch.not_found)
   );

endmodule
